/* design/qmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_pkg - shared types and constants for the quad motor mixer
// Fixed-point formats, mixing modes, register indexes and the constants of
// the throttle and PWM compare conversion.
// ----------------------------------------------------------------------------
package qmm_pkg;

  // Mixing modes held in the mix_mode register
  typedef enum logic [1:0] {
    MODE_QUAD  = 2'd0,
    MODE_PITCH = 2'd1,
    MODE_ROLL  = 2'd2,
    MODE_HOLD  = 2'd3
  } mix_mode_e;

  // Configuration register indexes
  localparam logic [1:0] REG_MIX_MODE     = 2'd0;
  localparam logic [1:0] REG_ARM_GAIN     = 2'd1;
  localparam logic [1:0] REG_YAW_GAIN     = 2'd2;
  localparam logic [1:0] REG_QUARTER_MASS = 2'd3;

  // Register reset values
  localparam logic [15:0] ARM_GAIN_RST     = 16'd1024;
  localparam logic [15:0] YAW_GAIN_RST     = 16'd1024;
  localparam logic [15:0] QUARTER_MASS_RST = 16'd256;

  // Hover acceleration 9.794 in Q5.10
  localparam logic signed [15:0] HOVER_Q10 = 16'sd10029;

  // Throttle: t = 210*F + 80*1024, throttle = t >> 10, clamped
  localparam int ThrGain   = 210;
  localparam int ThrOffset = 81920;
  localparam int ThrMin    = 100;
  localparam int ThrMax    = 900;

  // Compare: (25*(throttle+1000)) >> 2
  localparam int ThrBias = 1000;
  localparam int CmpNum  = 25;

  localparam logic [13:0] IDLE_COMPARE = 14'd6250;
  localparam logic [13:0] CMP_LO       = 14'd6875;
  localparam logic [13:0] CMP_HI       = 14'd11875;

  // Motor force, signed Q13.10
  typedef logic signed [23:0] force_t;

  // Control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic low;
  } stage_ctrl_t;

endpackage

/* design/qmm_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_mixer - demand scaling and X-frame force mixing
// Stage one forms the five demand-by-gain products, stage two sums them per
// motor into Q.10 forces and keeps the last forces for hold mode.
// ----------------------------------------------------------------------------
module qmm_mixer
  import qmm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  low_power_i,
  input  logic signed [15:0]    pitch_demand_i,
  input  logic signed [15:0]    roll_demand_i,
  input  logic signed [15:0]    yaw_demand_i,
  input  logic signed [15:0]    lift_demand_i,
  input  mix_mode_e             mix_mode_i,
  input  logic [15:0]           arm_gain_i,
  input  logic [15:0]           yaw_gain_i,
  input  logic [15:0]           quarter_mass_i,
  output force_t [3:0]          force_o,
  output stage_ctrl_t           ctrl_o
);

  typedef logic signed [31:0] prod_t;
  typedef logic signed [33:0] sum_t;

  // Signed Q5.10 demand times unsigned Q6.10 gain, exact in 32 bits
  function automatic prod_t mul_dg(input logic signed [15:0] d, input logic [15:0] g);
    logic signed [32:0] p;
    p = $signed({{17{d[15]}}, d}) * $signed({17'b0, g});
    return p[31:0];
  endfunction

  prod_t       pa_q, ra_q, yg_q, lm_q, hm_q;
  mix_mode_e   mode_q;
  stage_ctrl_t ctrl1_q, ctrl2_q;
  force_t [3:0] force_q;
  sum_t   [3:0] sum_d;
  sum_t        pa, ra, yg, lm, hm;

  // Stage one: products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
    end else begin
      ctrl1_q.valid <= in_valid_i;
      ctrl1_q.low   <= low_power_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      pa_q   <= mul_dg(pitch_demand_i, arm_gain_i);
      ra_q   <= mul_dg(roll_demand_i, arm_gain_i);
      yg_q   <= mul_dg(yaw_demand_i, yaw_gain_i);
      lm_q   <= mul_dg(lift_demand_i, quarter_mass_i);
      hm_q   <= mul_dg(HOVER_Q10, quarter_mass_i);
      mode_q <= mix_mode_i;
    end
  end

  // Stage two: per-motor sums
  always_comb begin
    pa = sum_t'(pa_q);
    ra = sum_t'(ra_q);
    yg = sum_t'(yg_q);
    lm = sum_t'(lm_q);
    hm = sum_t'(hm_q);
    case (mode_q)
      MODE_QUAD: begin
        sum_d[0] = -pa - ra - yg + lm;
        sum_d[1] =  pa - ra + yg + lm;
        sum_d[2] =  pa + ra - yg + lm;
        sum_d[3] = -pa + ra + yg + lm;
      end
      MODE_PITCH: begin
        sum_d[0] = hm - pa;
        sum_d[1] = hm + pa;
        sum_d[2] = hm + pa;
        sum_d[3] = hm - pa;
      end
      MODE_ROLL: begin
        sum_d[0] = hm - ra;
        sum_d[1] = hm - ra;
        sum_d[2] = hm + ra;
        sum_d[3] = hm + ra;
      end
      default: begin
        sum_d = '0;
      end
    endcase
  end

  // Hold the forces in hold mode; the floor shift of a 34-bit sum always
  // lands inside the 24-bit force range, so no saturation is needed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl2_q <= '0;
      force_q <= '0;
    end else begin
      ctrl2_q <= ctrl1_q;
      if (ctrl1_q.valid && (mode_q != MODE_HOLD)) begin
        for (int m = 0; m < 4; m++) begin
          force_q[m] <= sum_d[m][33:10];
        end
      end
    end
  end

  assign force_o = force_q;
  assign ctrl_o  = ctrl2_q;

endmodule

/* design/qmm_pwm_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_pwm_conv - force to throttle to PWM compare, four motor lanes
// Stage three scales each force to a Q.10 throttle, stage four clamps it and
// forms the compare value, or the idle value under low power.
// ----------------------------------------------------------------------------
module qmm_pwm_conv
  import qmm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  force_t [3:0]  force_i,
  input  stage_ctrl_t   ctrl_i,
  output logic [3:0][13:0] compare_o,
  output logic          done_o
);

  typedef logic signed [32:0] thr_q10_t;

  // Clamp a Q.10 throttle to whole units 100..900
  function automatic logic [9:0] clamp_thr(input thr_q10_t t);
    logic [21:0] raw;
    logic [9:0]  thr;
    raw = t[31:10];
    if (t[32]) begin
      thr = 10'(ThrMin);
    end else if (raw > 22'(ThrMax)) begin
      thr = 10'(ThrMax);
    end else if (raw < 22'(ThrMin)) begin
      thr = 10'(ThrMin);
    end else begin
      thr = raw[9:0];
    end
    return thr;
  endfunction

  // Compare = 6.25*(throttle+1000), truncated
  function automatic logic [13:0] thr_to_cmp(input logic [9:0] thr);
    logic [15:0] prod;
    prod = 16'(CmpNum) * (16'(thr) + 16'(ThrBias));
    return prod[15:2];
  endfunction

  stage_ctrl_t ctrl3_q;
  logic        done_q;
  thr_q10_t [3:0] t_q;
  logic [3:0][13:0] cmp_q;

  // Advance the control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl3_q <= '0;
      done_q  <= 1'b0;
    end else begin
      ctrl3_q <= ctrl_i;
      done_q  <= ctrl3_q.valid;
    end
  end

  for (genvar m = 0; m < 4; m++) begin : g_lane
    // Stage three: t = 210*F + 81920
    always_ff @(posedge clk_i) begin
      if (ctrl_i.valid) begin
        t_q[m] <= thr_q10_t'(force_i[m]) * thr_q10_t'(ThrGain) + thr_q10_t'(ThrOffset);
      end
    end

    // Stage four: clamp and convert
    always_ff @(posedge clk_i) begin
      if (ctrl3_q.valid) begin
        cmp_q[m] <= ctrl3_q.low ? IDLE_COMPARE : thr_to_cmp(clamp_thr(t_q[m]));
      end
    end
  end

  assign compare_o = cmp_q;
  assign done_o    = done_q;

endmodule

/* design/quad_motor_mixer_pwm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_motor_mixer_pwm_core - X-frame motor mixer with PWM compare output
// Mixes pitch, roll, yaw and lift demands into four motor forces and turns
// each into a PWM compare value.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start_i
//   high and busy_o low. busy_o stays low, so a new demand set may be
//   presented in every cycle.
//   Result channel: done_o pulses for one cycle with compare_m1_o to
//   compare_m4_o valid; the receiver cannot stall and must take it then.
//   A transaction passes four register stages from the accepting edge to
//   the result, with done_o registered alongside the compare values:
//   products, force sums, throttle scaling, clamp and compare. Throughput
//   is one transaction per cycle, set by the four register stages, each
//   of which takes a new item every cycle.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 mix_mode, 1 arm_gain, 2 yaw_gain, 3 quarter_mass). Write only
//   while no transaction is in flight.
//   Reset: clears the pipeline valid bits and the held forces and loads the register
//   defaults (four-axis mode, unit arm and yaw gains, quarter mass 0.25).
// ----------------------------------------------------------------------------
module quad_motor_mixer_pwm_core
  import qmm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] pitch_demand_i,
  input  logic signed [15:0] roll_demand_i,
  input  logic signed [15:0] yaw_demand_i,
  input  logic signed [15:0] lift_demand_i,
  input  logic               low_power_i,
  output logic               done_o,
  output logic [13:0]        compare_m1_o,
  output logic [13:0]        compare_m2_o,
  output logic [13:0]        compare_m3_o,
  output logic [13:0]        compare_m4_o
);

  mix_mode_e   mix_mode_q;
  logic [15:0] arm_gain_q;
  logic [15:0] yaw_gain_q;
  logic [15:0] quarter_mass_q;
  logic        accept;
  force_t [3:0] force_w;
  stage_ctrl_t  mix_ctrl;
  logic [3:0][13:0] compare_w;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_mode_q     <= MODE_QUAD;
      arm_gain_q     <= ARM_GAIN_RST;
      yaw_gain_q     <= YAW_GAIN_RST;
      quarter_mass_q <= QUARTER_MASS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIX_MODE:     mix_mode_q     <= mix_mode_e'(cfg_wdata_i[1:0]);
        REG_ARM_GAIN:     arm_gain_q     <= cfg_wdata_i;
        REG_YAW_GAIN:     yaw_gain_q     <= cfg_wdata_i;
        REG_QUARTER_MASS: quarter_mass_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  qmm_mixer u_mixer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (accept),
    .low_power_i    (low_power_i),
    .pitch_demand_i (pitch_demand_i),
    .roll_demand_i  (roll_demand_i),
    .yaw_demand_i   (yaw_demand_i),
    .lift_demand_i  (lift_demand_i),
    .mix_mode_i     (mix_mode_q),
    .arm_gain_i     (arm_gain_q),
    .yaw_gain_i     (yaw_gain_q),
    .quarter_mass_i (quarter_mass_q),
    .force_o        (force_w),
    .ctrl_o         (mix_ctrl)
  );

  qmm_pwm_conv u_pwm_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .force_i   (force_w),
    .ctrl_i    (mix_ctrl),
    .compare_o (compare_w),
    .done_o    (done_o)
  );

  assign compare_m1_o = compare_w[0];
  assign compare_m2_o = compare_w[1];
  assign compare_m3_o = compare_w[2];
  assign compare_m4_o = compare_w[3];

endmodule

/* design/qmm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_checker - port-level checks for the quad motor mixer
// Watches the command and result ports for latency and compare values.
// ----------------------------------------------------------------------------
module qmm_checker
  import qmm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        low_power_i,
  input logic        done_o,
  input logic [13:0] compare_m1_o,
  input logic [13:0] compare_m2_o,
  input logic [13:0] compare_m3_o,
  input logic [13:0] compare_m4_o
);

  // Every accepted transaction gives a result
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("result missing four cycles after a transaction");

  // No result without an earlier accepted transaction
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result without a transaction");

  // Low power forces every compare to idle
  a_low_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(low_power_i, 4)) |->
      (compare_m1_o == IDLE_COMPARE) && (compare_m2_o == IDLE_COMPARE) &&
      (compare_m3_o == IDLE_COMPARE) && (compare_m4_o == IDLE_COMPARE))
    else $error("low power compare not idle");

  // Otherwise compares lie in the clamped throttle span
  a_cmp_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(low_power_i, 4)) |->
      (compare_m1_o >= CMP_LO) && (compare_m1_o <= CMP_HI) &&
      (compare_m2_o >= CMP_LO) && (compare_m2_o <= CMP_HI) &&
      (compare_m3_o >= CMP_LO) && (compare_m3_o <= CMP_HI) &&
      (compare_m4_o >= CMP_LO) && (compare_m4_o <= CMP_HI))
    else $error("compare outside throttle span");

endmodule

bind quad_motor_mixer_pwm_core qmm_checker u_qmm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .low_power_i  (low_power_i),
  .done_o       (done_o),
  .compare_m1_o (compare_m1_o),
  .compare_m2_o (compare_m2_o),
  .compare_m3_o (compare_m3_o),
  .compare_m4_o (compare_m4_o)
);
